FILE: design/sc2c_pkg.sv
// ----------------------------------------------------------------------------
// sc2c_pkg
// Shared types, constants and translation tables of the scan code translator.
// ----------------------------------------------------------------------------
package sc2c_pkg;

	localparam int NUM_TERMINALS = 4;
	localparam int TERM_IDX_W    = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;

	localparam logic [6:0] ACCENT_RESET = 7'd40;

	// configuration register indexes
	localparam logic CFG_ACCENT = 1'b0;
	localparam logic CFG_SCROLL = 1'b1;

	// key kinds
	localparam logic [1:0] KIND_PRIVATE   = 2'd0;
	localparam logic [1:0] KIND_PRINTABLE = 2'd1;
	localparam logic [1:0] KIND_SPECIAL   = 2'd2;

	// scan codes with a fixed meaning
	localparam logic [7:0] SC_CAPS     = 8'd58;
	localparam logic [7:0] SC_LSHIFT   = 8'd42;
	localparam logic [7:0] SC_RSHIFT   = 8'd54;
	localparam logic [7:0] SC_LSHIFT_R = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_R = 8'hB6;
	localparam logic [7:0] SC_NUM      = 8'd69;
	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_CTRL     = 8'd29;
	localparam logic [7:0] SC_ALT      = 8'd56;
	localparam logic [7:0] SC_F1       = 8'd59;
	localparam logic [7:0] SC_F10      = 8'd68;
	localparam logic [7:0] SC_F11      = 8'd87;
	localparam logic [7:0] SC_F12      = 8'd88;
	localparam logic [7:0] SC_KP_FIRST = 8'd71;
	localparam logic [7:0] SC_KP_LAST  = 8'd83;
	localparam logic [7:0] SC_KP_MINUS = 8'd74;
	localparam logic [7:0] SC_KP_PLUS  = 8'd78;

	localparam logic [8:0] ESC_OFFSET = 9'h100;

	typedef struct packed {
		logic acc;
		logic esc;
		logic num;
		logic shift;
		logic caps;
	} flags_t;

	typedef struct packed {
		logic [1:0] key_kind;
		logic [8:0] key_code;
		logic [7:0] char_code;
		logic       led_write;
		logic [2:0] led_bits;
	} result_t;

	// fold the terminal field onto the terminals present
	function automatic logic [TERM_IDX_W-1:0] term_index(input logic [1:0] t);
		logic [2:0] v;
		v = {1'b0, t};
		if (NUM_TERMINALS == 1) begin
			v = 3'd0;
		end else if (NUM_TERMINALS < 4) begin
			if (v >= 3'(NUM_TERMINALS))
				v = v - 3'(NUM_TERMINALS);
		end
		return TERM_IDX_W'(v);
	endfunction

	function automatic logic [7:0] plain_char(input logic [6:0] s);
		logic [7:0] c;
		case (s)
			7'd1:  c = 8'd27;
			7'd2:  c = "1";
			7'd3:  c = "2";
			7'd4:  c = "3";
			7'd5:  c = "4";
			7'd6:  c = "5";
			7'd7:  c = "6";
			7'd8:  c = "7";
			7'd9:  c = "8";
			7'd10: c = "9";
			7'd11: c = "0";
			7'd12: c = "-";
			7'd13: c = "=";
			7'd14: c = 8'd8;
			7'd15: c = 8'd9;
			7'd16: c = "q";
			7'd17: c = "w";
			7'd18: c = "e";
			7'd19: c = "r";
			7'd20: c = "t";
			7'd21: c = "y";
			7'd22: c = "u";
			7'd23: c = "i";
			7'd24: c = "o";
			7'd25: c = "p";
			7'd26: c = "[";
			7'd27: c = "]";
			7'd28: c = 8'd10;
			7'd30: c = "a";
			7'd31: c = "s";
			7'd32: c = "d";
			7'd33: c = "f";
			7'd34: c = "g";
			7'd35: c = "h";
			7'd36: c = "j";
			7'd37: c = "k";
			7'd38: c = "l";
			7'd39: c = 8'd164;
			7'd40: c = "'";
			7'd43: c = "\\";
			7'd44: c = "z";
			7'd45: c = "x";
			7'd46: c = "c";
			7'd47: c = "v";
			7'd48: c = "b";
			7'd49: c = "n";
			7'd50: c = "m";
			7'd51: c = ",";
			7'd52: c = ".";
			7'd53: c = "/";
			7'd55: c = "*";
			7'd57: c = " ";
			7'd70: c = 8'd70;
			7'd71: c = 8'd71;
			7'd72: c = 8'd72;
			7'd73: c = 8'd73;
			7'd74: c = "-";
			7'd75: c = 8'd75;
			7'd76: c = 8'd76;
			7'd77: c = 8'd77;
			7'd78: c = "+";
			7'd79: c = 8'd79;
			7'd80: c = 8'd80;
			7'd81: c = 8'd81;
			7'd82: c = 8'd82;
			7'd83: c = 8'd83;
			7'd86: c = "<";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shift_char(input logic [6:0] s);
		logic [7:0] c;
		case (s)
			7'd2:  c = "!";
			7'd3:  c = "@";
			7'd4:  c = "#";
			7'd5:  c = "$";
			7'd6:  c = "%";
			7'd7:  c = "^";
			7'd8:  c = "&";
			7'd9:  c = "*";
			7'd10: c = "(";
			7'd11: c = ")";
			7'd12: c = "_";
			7'd13: c = "+";
			7'd16: c = "Q";
			7'd17: c = "W";
			7'd18: c = "E";
			7'd19: c = "R";
			7'd20: c = "T";
			7'd21: c = "Y";
			7'd22: c = "U";
			7'd23: c = "I";
			7'd24: c = "O";
			7'd25: c = "P";
			7'd26: c = "{";
			7'd27: c = "}";
			7'd30: c = "A";
			7'd31: c = "S";
			7'd32: c = "D";
			7'd33: c = "F";
			7'd34: c = "G";
			7'd35: c = "H";
			7'd36: c = "J";
			7'd37: c = "K";
			7'd38: c = "L";
			7'd39: c = 8'd165;
			7'd43: c = "|";
			7'd44: c = "Z";
			7'd45: c = "X";
			7'd46: c = "C";
			7'd47: c = "V";
			7'd48: c = "B";
			7'd49: c = "N";
			7'd50: c = "M";
			7'd51: c = "<";
			7'd52: c = ">";
			7'd53: c = "?";
			7'd86: c = ">";
			default: c = plain_char(s);
		endcase
		return c;
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) || (c == 8'd165);
	endfunction

	function automatic logic [7:0] keypad_char(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'd71:   r = "7";
			8'd72:   r = "8";
			8'd73:   r = "9";
			8'd75:   r = "4";
			8'd76:   r = "5";
			8'd77:   r = "6";
			8'd79:   r = "1";
			8'd80:   r = "2";
			8'd81:   r = "3";
			8'd82:   r = "0";
			8'd83:   r = ".";
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] add_accent(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			"a":     r = 8'd160;
			"e":     r = 8'd130;
			"i":     r = 8'd161;
			"o":     r = 8'd162;
			"u":     r = 8'd163;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

FILE: design/sc2c_if.sv
// ----------------------------------------------------------------------------
// sc2c_in_if / sc2c_out_if
// Valid/ready channels for scan bytes in and translated results out.
// ----------------------------------------------------------------------------
interface sc2c_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] terminal;
	logic [7:0] scan_byte;

	modport source (output valid, output terminal, output scan_byte, input ready);
	modport sink   (input valid, input terminal, input scan_byte, output ready);
endinterface

interface sc2c_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] key_kind;
	logic [8:0] key_code;
	logic [7:0] char_code;
	logic       led_write;
	logic [2:0] led_bits;

	modport source (output valid, output key_kind, output key_code, output char_code,
		output led_write, output led_bits, input ready);
	modport sink   (input valid, input key_kind, input key_code, input char_code,
		input led_write, input led_bits, output ready);
endinterface

FILE: design/scan_code_to_char_translator.sv
// ----------------------------------------------------------------------------
// scan_code_to_char_translator
// Set-1 scan byte to character translator with per-terminal lock flags.
// ----------------------------------------------------------------------------
// An accepted item is registered into stage 1, where its flags are read, and
// its result into the output register; stage 1 holds while the output stalls.
// Throughput: one item per cycle unless the output stalls, set by the flag
// memory read-modify-write, forwarding when consecutive items hit one terminal.
// Reset: flags of all terminals read as cleared at once through entry valid
// bits; last result clears to private kind and zero character.
module scan_code_to_char_translator (
	input  logic              clk,
	input  logic              arst_n,
	sc2c_in_if.sink           in_ch,
	sc2c_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_data
);

	logic                            in_fire;
	logic                            s1_fire;
	logic                            s1_valid_q;
	logic [sc2c_pkg::TERM_IDX_W-1:0] in_term;
	logic [sc2c_pkg::TERM_IDX_W-1:0] term_s1;
	logic [7:0]                      scan_s1;
	logic                            hit_s1;
	sc2c_pkg::flags_t                fwd_s1;
	sc2c_pkg::flags_t                mem_flags;
	sc2c_pkg::flags_t                cur_flags;
	sc2c_pkg::flags_t                new_flags;
	sc2c_pkg::result_t               res;
	sc2c_pkg::result_t               res_q;
	logic                            out_valid_q;
	logic [1:0]                      last_kind_q;
	logic [7:0]                      last_char_q;
	logic [6:0]                      accent_q;
	logic                            scroll_q;

	assign in_term  = sc2c_pkg::term_index(in_ch.terminal);
	assign s1_fire  = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid_q || s1_fire;
	assign in_fire  = in_ch.valid && in_ch.ready;

	sc2c_flag_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_term),
		.rd_data (mem_flags),
		.wr_en   (s1_fire),
		.wr_addr (term_s1),
		.wr_data (new_flags)
	);

	// take the flags written as this item was accepted when it read that same entry
	assign cur_flags = hit_s1 ? fwd_s1 : mem_flags;

	sc2c_decode u_dec (
		.scan      (scan_s1),
		.flags     (cur_flags),
		.accent    (accent_q),
		.scroll    (scroll_q),
		.last_kind (last_kind_q),
		.last_char (last_char_q),
		.flags_nxt (new_flags),
		.res       (res)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			term_s1 <= in_term;
			scan_s1 <= in_ch.scan_byte;
			fwd_s1  <= new_flags;
		end
		if (s1_fire)
			res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			hit_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			last_kind_q <= sc2c_pkg::KIND_PRIVATE;
			last_char_q <= 8'd0;
			accent_q    <= sc2c_pkg::ACCENT_RESET;
			scroll_q    <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
				hit_s1     <= s1_fire && (term_s1 == in_term);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				last_kind_q <= res.key_kind;
				last_char_q <= res.char_code;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					sc2c_pkg::CFG_ACCENT: accent_q <= cfg_data;
					sc2c_pkg::CFG_SCROLL: scroll_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.key_kind  = res_q.key_kind;
	assign out_ch.key_code  = res_q.key_code;
	assign out_ch.char_code = res_q.char_code;
	assign out_ch.led_write = res_q.led_write;
	assign out_ch.led_bits  = res_q.led_bits;

	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_valid_q)
		else $error("processed item did not reach the output register");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_fire) |-> !in_fire)
		else $error("item accepted while stage 1 is stalled");

	a_led_is_private: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.led_write) |-> (res_q.key_kind == sc2c_pkg::KIND_PRIVATE))
		else $error("LED update on a non-private result");

	a_escaped_special: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.key_code[8]) |-> (res_q.key_kind == sc2c_pkg::KIND_SPECIAL))
		else $error("escaped key code without special kind");

endmodule

FILE: design/sc2c_flag_mem.sv
// ----------------------------------------------------------------------------
// sc2c_flag_mem
// Per-terminal flag memory, one write and one registered read per cycle.
// Entry valid bits make every entry read as cleared flags after reset.
// ----------------------------------------------------------------------------
module sc2c_flag_mem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [sc2c_pkg::TERM_IDX_W-1:0] rd_addr,
	output sc2c_pkg::flags_t                rd_data,
	input  logic                            wr_en,
	input  logic [sc2c_pkg::TERM_IDX_W-1:0] wr_addr,
	input  sc2c_pkg::flags_t                wr_data
);

	sc2c_pkg::flags_t                         mem [sc2c_pkg::NUM_TERMINALS];
	sc2c_pkg::flags_t                         rd_q;
	logic                                     rd_vld_q;
	logic [sc2c_pkg::NUM_TERMINALS-1:0]       vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: design/sc2c_decode.sv
// ----------------------------------------------------------------------------
// sc2c_decode
// Translates one scan byte against the terminal flags and the last result,
// giving the new flags and the result item.
// ----------------------------------------------------------------------------
module sc2c_decode (
	input  logic [7:0]        scan,
	input  sc2c_pkg::flags_t  flags,
	input  logic [6:0]        accent,
	input  logic              scroll,
	input  logic [1:0]        last_kind,
	input  logic [7:0]        last_char,
	output sc2c_pkg::flags_t  flags_nxt,
	output sc2c_pkg::result_t res
);

	logic [7:0] pc;
	logic [7:0] sc;
	logic [7:0] c;
	logic [1:0] kind;
	logic [7:0] chr;
	logic [8:0] key;
	logic       ledw;
	logic       kp_rule;
	logic       is_kp;
	sc2c_pkg::flags_t f;

	assign pc    = sc2c_pkg::plain_char(scan[6:0]);
	assign sc    = sc2c_pkg::shift_char(scan[6:0]);
	assign is_kp = (scan >= sc2c_pkg::SC_KP_FIRST) && (scan <= sc2c_pkg::SC_KP_LAST)
		&& (scan != sc2c_pkg::SC_KP_MINUS) && (scan != sc2c_pkg::SC_KP_PLUS);

	always_comb begin
		f       = flags;
		kind    = last_kind;
		chr     = last_char;
		key     = {1'b0, scan};
		ledw    = 1'b0;
		kp_rule = 1'b1;
		c       = pc;
		if (scan == sc2c_pkg::SC_CAPS) begin
			kind   = sc2c_pkg::KIND_PRIVATE;
			f.caps = ~f.caps;
			ledw   = 1'b1;
		end else if (scan == sc2c_pkg::SC_LSHIFT || scan == sc2c_pkg::SC_RSHIFT
			|| scan == sc2c_pkg::SC_LSHIFT_R || scan == sc2c_pkg::SC_RSHIFT_R) begin
			kind    = sc2c_pkg::KIND_PRIVATE;
			f.shift = ~f.shift;
		end else if (scan == sc2c_pkg::SC_NUM) begin
			kind  = sc2c_pkg::KIND_PRIVATE;
			f.num = ~f.num;
			ledw  = 1'b1;
		end else if (scan == sc2c_pkg::SC_PREFIX) begin
			kind  = sc2c_pkg::KIND_PRIVATE;
			f.esc = 1'b1;
		end else if (scan == sc2c_pkg::SC_CTRL || scan == sc2c_pkg::SC_ALT) begin
			kind = sc2c_pkg::KIND_PRIVATE;
		end else if ((scan >= sc2c_pkg::SC_F1 && scan <= sc2c_pkg::SC_F10)
			|| scan == sc2c_pkg::SC_F11 || scan == sc2c_pkg::SC_F12) begin
			kind = sc2c_pkg::KIND_SPECIAL;
		end else if (scan == {1'b0, accent}) begin
			f.acc = 1'b1;
		end else if (scan[7]) begin
			kind = sc2c_pkg::KIND_PRIVATE;
		end else if (f.esc) begin
			kind    = sc2c_pkg::KIND_SPECIAL;
			key     = {1'b0, scan} + sc2c_pkg::ESC_OFFSET;
			f.esc   = 1'b0;
			kp_rule = 1'b0;
		end else begin
			kind = sc2c_pkg::KIND_PRINTABLE;
			// caps flips case of letters only, shift or not
			if (f.shift)
				c = (sc2c_pkg::is_upper(sc) && f.caps) ? pc : sc;
			else if (!f.caps)
				c = pc;
			else
				c = sc2c_pkg::is_upper(sc) ? sc : pc;
			if (f.acc) begin
				c     = sc2c_pkg::add_accent(c);
				f.acc = 1'b0;
			end
			chr = c;
		end

		if (kp_rule && is_kp) begin
			if (f.num) begin
				kind = sc2c_pkg::KIND_PRINTABLE;
				chr  = sc2c_pkg::keypad_char(chr);
			end else begin
				kind = sc2c_pkg::KIND_PRIVATE;
				chr  = 8'd0;
			end
		end
	end

	assign flags_nxt     = f;
	assign res.key_kind  = kind;
	assign res.key_code  = key;
	assign res.char_code = chr;
	assign res.led_write = ledw;
	assign res.led_bits  = {f.caps, f.num, scroll};

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the scan code translator. Scan bytes are fed on random
// terminals through the input channel while the result channel stalls at
// random. Every result is checked field by field against a translation
// predicted locally from the flags, the keyboard maps and the registers.
// ----------------------------------------------------------------------------
module tb_top;
	import sc2c_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASE_BYTES = 130;

	typedef struct packed {
		logic [1:0] term;
		logic [7:0] code;
	} scan_item_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [6:0] cfg_data;

	sc2c_in_if  kbd_in ();
	sc2c_out_if char_out ();

	scan_code_to_char_translator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (kbd_in),
		.out_ch    (char_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// keyboard maps and translator state as predicted
	logic [7:0] plain_map [128];
	logic [7:0] shift_map [128];
	flags_t     term_flags [NUM_TERMINALS];
	logic [1:0] shown_kind;
	logic [7:0] shown_char;
	logic [6:0] accent_cfg;
	logic       scroll_cfg;

	scan_item_t key_byte_q [$];
	result_t    awaited_keys [$];

	int  bytes_queued;
	int  bytes_taken;
	int  mismatches;
	int  printable_seen;
	int  special_seen;
	int  led_seen;
	int  settings_used;
	int  cycle_cnt;
	bit  in_taken;
	bit  steady;

	always #5 clk = ~clk;

	function automatic void load_row(input bit shifted, input int base, input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			if (shifted)
				shift_map[base + i] = s[i];
			else
				plain_map[base + i] = s[i];
		end
	endfunction

	function automatic logic is_capital(input logic [7:0] c);
		return ((c >= 8'd65) && (c <= 8'd90)) || (c == 8'd165);
	endfunction

	function automatic result_t translate_byte(input logic [1:0] term, input logic [7:0] sc);
		int         idx;
		flags_t     f;
		result_t    r;
		logic [8:0] code;
		logic       led;
		logic       keypad_ok;
		logic [7:0] c;
		idx = term % NUM_TERMINALS;
		f = term_flags[idx];
		code = {1'b0, sc};
		led = 1'b0;
		keypad_ok = 1'b1;
		if (sc == SC_CAPS) begin
			shown_kind = KIND_PRIVATE;
			f.caps = ~f.caps;
			led = 1'b1;
		end else if (sc == SC_LSHIFT || sc == SC_RSHIFT || sc == SC_LSHIFT_R ||
				sc == SC_RSHIFT_R) begin
			shown_kind = KIND_PRIVATE;
			f.shift = ~f.shift;
		end else if (sc == SC_NUM) begin
			shown_kind = KIND_PRIVATE;
			f.num = ~f.num;
			led = 1'b1;
		end else if (sc == SC_PREFIX) begin
			shown_kind = KIND_PRIVATE;
			f.esc = 1'b1;
		end else if (sc == SC_CTRL || sc == SC_ALT) begin
			shown_kind = KIND_PRIVATE;
		end else if ((sc >= SC_F1 && sc <= SC_F10) || sc == SC_F11 || sc == SC_F12) begin
			shown_kind = KIND_SPECIAL;
		end else if (sc == {1'b0, accent_cfg}) begin
			// arm the accent; kind and character stay as they were
			f.acc = 1'b1;
		end else if (sc[7]) begin
			shown_kind = KIND_PRIVATE;
		end else if (f.esc) begin
			shown_kind = KIND_SPECIAL;
			code = {1'b0, sc} + ESC_OFFSET;
			f.esc = 1'b0;
			keypad_ok = 1'b0;
		end else begin
			shown_kind = KIND_PRINTABLE;
			if (f.shift) begin
				c = shift_map[sc[6:0]];
				if (is_capital(c) && f.caps)
					c = plain_map[sc[6:0]];
			end else if (!f.caps) begin
				c = plain_map[sc[6:0]];
			end else begin
				c = shift_map[sc[6:0]];
				if (!is_capital(c))
					c = plain_map[sc[6:0]];
			end
			if (f.acc) begin
				case (c)
					"a": c = 8'd160;
					"e": c = 8'd130;
					"i": c = 8'd161;
					"o": c = 8'd162;
					"u": c = 8'd163;
					default: ;
				endcase
				f.acc = 1'b0;
			end
			shown_char = c;
		end
		if (keypad_ok && sc >= SC_KP_FIRST && sc <= SC_KP_LAST && sc != SC_KP_MINUS &&
				sc != SC_KP_PLUS) begin
			if (f.num) begin
				shown_kind = KIND_PRINTABLE;
				case (shown_char)
					8'd71: shown_char = "7";
					8'd72: shown_char = "8";
					8'd73: shown_char = "9";
					8'd75: shown_char = "4";
					8'd76: shown_char = "5";
					8'd77: shown_char = "6";
					8'd79: shown_char = "1";
					8'd80: shown_char = "2";
					8'd81: shown_char = "3";
					8'd82: shown_char = "0";
					8'd83: shown_char = ".";
					default: ;
				endcase
			end else begin
				shown_kind = KIND_PRIVATE;
				shown_char = 8'd0;
			end
		end
		term_flags[idx] = f;
		r.key_kind  = shown_kind;
		r.key_code  = code;
		r.char_code = shown_char;
		r.led_write = led;
		r.led_bits  = {f.caps, f.num, scroll_cfg};
		return r;
	endfunction

	task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_byte(input logic [1:0] term, input logic [7:0] code);
		scan_item_t it;
		it.term = term;
		it.code = code;
		key_byte_q.push_back(it);
		bytes_queued++;
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACCENT)
			accent_cfg = data;
		else
			scroll_cfg = data[0];
	endtask

	// hold until every queued byte went in and every result came out
	task automatic drain();
		while (bytes_taken != bytes_queued || awaited_keys.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one typing burst: mostly realistic key sequences, some noise
	task automatic add_burst();
		logic [1:0] t;
		int         pick;
		int         k;
		t = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			k = $urandom_range(1, 127);
			queue_byte(t, 8'(k));
			if ($urandom_range(0, 1))
				queue_byte(t, 8'(k) | 8'h80);
		end else if (pick < 42) begin
			queue_byte(t, $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
			repeat ($urandom_range(1, 3)) queue_byte(t, 8'($urandom_range(1, 86)));
			queue_byte(t, $urandom_range(0, 1) ? SC_LSHIFT_R : SC_RSHIFT_R);
		end else if (pick < 48) begin
			queue_byte(t, SC_CAPS);
		end else if (pick < 54) begin
			queue_byte(t, SC_NUM);
		end else if (pick < 64) begin
			queue_byte(t, 8'($urandom_range(SC_KP_FIRST, SC_KP_LAST)));
		end else if (pick < 72) begin
			queue_byte(t, SC_PREFIX);
			queue_byte(t, 8'($urandom_range(0, 255)));
		end else if (pick < 80) begin
			queue_byte(t, {1'b0, accent_cfg});
			case ($urandom_range(0, 5))
				0: queue_byte(t, 8'd30);
				1: queue_byte(t, 8'd18);
				2: queue_byte(t, 8'd23);
				3: queue_byte(t, 8'd24);
				4: queue_byte(t, 8'd22);
				default: queue_byte(t, 8'($urandom_range(0, 127)));
			endcase
		end else if (pick < 88) begin
			case ($urandom_range(0, 3))
				0: queue_byte(t, SC_CTRL);
				1: queue_byte(t, SC_ALT);
				2: queue_byte(t, 8'($urandom_range(SC_F1, SC_F10)));
				default: queue_byte(t, $urandom_range(0, 1) ? SC_F11 : SC_F12);
			endcase
		end else begin
			queue_byte(t, 8'($urandom_range(0, 255)));
		end
	endtask

	// driver: advance to the next byte once the current one is taken
	always @(negedge clk) begin
		scan_item_t nxt;
		if (!arst_n) begin
			kbd_in.valid <= 1'b0;
		end else if (!kbd_in.valid || in_taken) begin
			if (key_byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= 18)) begin
				nxt = key_byte_q.pop_front();
				kbd_in.valid     <= 1'b1;
				kbd_in.terminal  <= nxt.term;
				kbd_in.scan_byte <= nxt.code;
			end else begin
				kbd_in.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		char_out.ready <= arst_n && (steady || $urandom_range(0, 99) >= 18);

	always @(negedge clk)
		steady <= (bytes_taken >= 300 && bytes_taken < 420);

	// monitor: predict on every taken byte, check every delivered result
	always @(posedge clk) begin
		result_t want;
		in_taken = arst_n && kbd_in.valid && kbd_in.ready;
		if (in_taken) begin
			awaited_keys.push_back(translate_byte(kbd_in.terminal, kbd_in.scan_byte));
			bytes_taken++;
		end
		if (arst_n && char_out.valid && char_out.ready) begin
			if (awaited_keys.size() == 0) begin
				$error("result with no scan byte pending: kind %0d code %0d",
					char_out.key_kind, char_out.key_code);
				mismatches++;
			end else begin
				want = awaited_keys.pop_front();
				check_field("key_kind", 9'(want.key_kind), 9'(char_out.key_kind));
				check_field("key_code", want.key_code, char_out.key_code);
				check_field("char_code", 9'(want.char_code), 9'(char_out.char_code));
				check_field("led_write", 9'(want.led_write), 9'(char_out.led_write));
				check_field("led_bits", 9'(want.led_bits), 9'(char_out.led_bits));
				if (want.key_kind == KIND_PRINTABLE)
					printable_seen++;
				if (want.key_kind == KIND_SPECIAL)
					special_seen++;
				if (want.led_write)
					led_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [6:0] accent_plan [5];
		logic       scroll_plan [5];
		int         phase;
		int         target;
		int         i;
		accent_plan = '{7'd0, 7'd127, 7'd71, 7'd39, 7'd40};
		scroll_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		for (i = 0; i < 128; i++) begin
			plain_map[i] = 8'd0;
		end
		plain_map[1]  = 8'd27;
		plain_map[14] = 8'd8;
		plain_map[15] = 8'd9;
		plain_map[28] = 8'd10;
		plain_map[39] = 8'd164;
		plain_map[40] = "'";
		plain_map[43] = "\\";
		plain_map[55] = "*";
		plain_map[57] = " ";
		plain_map[86] = "<";
		for (i = 70; i <= 83; i++)
			plain_map[i] = 8'(i);
		plain_map[74] = "-";
		plain_map[78] = "+";
		load_row(1'b0, 2, "1234567890-=");
		load_row(1'b0, 16, "qwertyuiop[]");
		load_row(1'b0, 30, "asdfghjkl");
		load_row(1'b0, 44, "zxcvbnm,./");
		shift_map = plain_map;
		load_row(1'b1, 2, "!@#$%^&*()_+");
		load_row(1'b1, 16, "QWERTYUIOP{}");
		load_row(1'b1, 30, "ASDFGHJKL");
		load_row(1'b1, 44, "ZXCVBNM<>?");
		shift_map[39] = 8'd165;
		shift_map[43] = "|";
		shift_map[86] = ">";

		for (i = 0; i < NUM_TERMINALS; i++)
			term_flags[i] = '0;
		shown_kind = KIND_PRIVATE;
		shown_char = 8'd0;
		accent_cfg = ACCENT_RESET;
		scroll_cfg = 1'b0;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ACCENT;
		cfg_data = 7'd0;
		kbd_in.valid = 1'b0;
		kbd_in.terminal = 2'd0;
		kbd_in.scan_byte = 8'd0;
		char_out.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, every lock and modifier, accent, prefix, keypad
		@(posedge clk);
		queue_byte(2'd0, 8'h00);      queue_byte(2'd3, 8'hFF);
		queue_byte(2'd1, SC_CAPS);    queue_byte(2'd1, 8'd30);
		queue_byte(2'd1, SC_LSHIFT);  queue_byte(2'd1, 8'd30);
		queue_byte(2'd1, 8'd39);      queue_byte(2'd1, SC_LSHIFT_R);
		queue_byte(2'd1, 8'd39);      queue_byte(2'd2, SC_RSHIFT);
		queue_byte(2'd2, 8'd2);       queue_byte(2'd2, SC_RSHIFT_R);
		queue_byte(2'd2, SC_NUM);     queue_byte(2'd2, SC_KP_FIRST);
		queue_byte(2'd2, SC_KP_LAST); queue_byte(2'd2, SC_KP_MINUS);
		queue_byte(2'd0, 8'd75);      queue_byte(2'd3, SC_PREFIX);
		queue_byte(2'd3, 8'd72);      queue_byte(2'd0, SC_CTRL);
		queue_byte(2'd0, SC_ALT);     queue_byte(2'd0, SC_F1);
		queue_byte(2'd0, SC_F12);     queue_byte(2'd0, {1'b0, ACCENT_RESET});
		queue_byte(2'd0, 8'd18);      queue_byte(2'd0, 8'h9E);
		drain();

		target = bytes_queued;
		for (phase = 0; phase < 5; phase++) begin
			write_reg(CFG_ACCENT, accent_plan[phase]);
			write_reg(CFG_SCROLL, {6'd0, scroll_plan[phase]});
			settings_used++;
			@(posedge clk);
			target += PHASE_BYTES;
			while (bytes_queued < target)
				add_burst();
			drain();
		end

		repeat (10) @(posedge clk);
		mismatches += awaited_keys.size();
		$display("Fed %0d scan bytes on %0d terminals under %0d register settings.",
			bytes_taken, NUM_TERMINALS, settings_used + 1);
		$display("Checked %0d printable, %0d special and %0d LED-update results.",
			printable_seen, special_seen, led_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
